// ===== hdl/i2c_register_access_master_assert.svh =====
// ----------------------------------------------------------------------------
// I2C register access master: assertion macros
// Shorthand for clocked assertions on clk with synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// Same-cycle implication.
`define I2CRAM_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("i2cram: same-cycle check failed");

// Next-cycle implication.
`define I2CRAM_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("i2cram: next-cycle check failed");

`endif

// ===== hdl/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register access master: package
// Action codes, segment codes, sequencer state and the program tables.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [3:0] SEG_START   = 4'd0;
  localparam logic [3:0] SEG_TX_DEV  = 4'd1;
  localparam logic [3:0] SEG_TX_REG  = 4'd2;
  localparam logic [3:0] SEG_TX_DATA = 4'd3;
  localparam logic [3:0] SEG_ACK     = 4'd4;
  localparam logic [3:0] SEG_TX_DEVR = 4'd5;
  localparam logic [3:0] SEG_RX      = 4'd6;
  localparam logic [3:0] SEG_NACK    = 4'd7;
  localparam logic [3:0] SEG_STOP    = 4'd8;

  // Index of the last segment of each program.
  localparam logic [3:0] WR_LAST = 4'd7;
  localparam logic [3:0] RD_LAST = 4'd10;

  // Phase that opens the receive segment (release SDA, clear shifter).
  localparam logic [1:0] PH_RX_PRE = 2'd3;

  localparam logic [7:0] READ_BIT = 8'h01;

  typedef struct packed {
    logic       active;
    logic       is_read;
    logic [3:0] seg_idx;
    logic [1:0] phase;
    logic [2:0] bit_cnt;
    logic [7:0] held_dev;
    logic [7:0] held_reg;
    logic [7:0] held_data;
    logic [7:0] shift_byte;
    logic [7:0] received_byte;
    logic       scl;
    logic       sda;
    logic       nack;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] dev_address;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_in_t;

  localparam seq_state_t ST_RESET = '{
    active: 1'b0, is_read: 1'b0, seg_idx: 4'd0, phase: 2'd0, bit_cnt: 3'd0,
    held_dev: 8'd0, held_reg: 8'd0, held_data: 8'd0, shift_byte: 8'd0,
    received_byte: 8'd0, scl: 1'b1, sda: 1'b1, nack: 1'b0
  };

  // Segment at a position of the write or read program.
  function automatic logic [3:0] seg_code(input logic is_read, input logic [3:0] idx);
    logic [3:0] code;
    code = SEG_STOP;
    if (is_read) begin
      case (idx)
        4'd0:    code = SEG_START;
        4'd1:    code = SEG_TX_DEV;
        4'd2:    code = SEG_ACK;
        4'd3:    code = SEG_TX_REG;
        4'd4:    code = SEG_ACK;
        4'd5:    code = SEG_START;
        4'd6:    code = SEG_TX_DEVR;
        4'd7:    code = SEG_ACK;
        4'd8:    code = SEG_RX;
        4'd9:    code = SEG_NACK;
        default: code = SEG_STOP;
      endcase
    end else begin
      case (idx)
        4'd0:    code = SEG_START;
        4'd1:    code = SEG_TX_DEV;
        4'd2:    code = SEG_ACK;
        4'd3:    code = SEG_TX_REG;
        4'd4:    code = SEG_ACK;
        4'd5:    code = SEG_TX_DATA;
        4'd6:    code = SEG_ACK;
        default: code = SEG_STOP;
      endcase
    end
    return code;
  endfunction

endpackage

// ===== hdl/i2cram_if.sv =====
// ----------------------------------------------------------------------------
// I2C register access master: channel interfaces
// Valid/ready channels for tick transactions and pin result transactions.
// ----------------------------------------------------------------------------
interface i2cram_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] dev_address;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, action, dev_address, reg_address, write_data, sda_in,
                  input ready);
  modport sink (input valid, action, dev_address, reg_address, write_data, sda_in,
                output ready);
endinterface

interface i2cram_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_seen;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                  nack_seen, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                nack_seen, output ready);
endinterface

// ===== hdl/i2c_register_access_master.sv =====
// ----------------------------------------------------------------------------
// I2C register access master: top level
// Bit-level I2C master for one register write or one register read.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per pacing tick. action 1 begins a register write,
//            action 2 a register read (both ignored while busy), 0 or 3 only
//            advance. sda_in is the sampled data line for this tick.
//   out_ch : one transaction per tick with the SCL/SDA drives after the tick,
//            busy, a done pulse on the final STOP operation, the last byte
//            read and the sticky NACK flag of the current or last transfer.
//   Each tick of a transfer performs exactly one pin operation; a write
//   takes 91 ticks and a read 123 ticks, counting the beginning tick.
//   Result: registered, it appears in the cycle after the tick is accepted.
//   Throughput: one tick per cycle while out_ch takes results, set by the
//   single sequencer step between the state register and the result register.
//   Reset: idle, both lines released high, flags and bytes cleared, no
//   result pending.
//   Stall: the result register holds while out_ch is not ready; in_ch stays
//   ready as long as the held result is taken in the same cycle.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_assert.svh"

module i2c_register_access_master (
  input  logic          clk,
  input  logic          rst_n,
  i2cram_in_if.sink     in_ch,
  i2cram_out_if.source  out_ch
);

  i2cram_pkg::seq_state_t st_r;
  i2cram_pkg::seq_state_t st_nxt;
  i2cram_pkg::tick_in_t   tick;
  logic                   done_nxt;
  logic                   in_fire;
  logic                   begin_fire;

  logic       out_valid_r;
  logic       scl_r;
  logic       sda_r;
  logic       busy_r;
  logic       done_r;
  logic [7:0] read_data_r;
  logic       nack_r;

  // Accept a tick whenever the result slot is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign begin_fire  = in_fire && !st_r.active &&
                       (in_ch.action == i2cram_pkg::ACT_WRITE ||
                        in_ch.action == i2cram_pkg::ACT_READ);

  assign tick.action      = in_ch.action;
  assign tick.dev_address = in_ch.dev_address;
  assign tick.reg_address = in_ch.reg_address;
  assign tick.write_data  = in_ch.write_data;
  assign tick.sda_in      = in_ch.sda_in;

  i2cram_step u_step (
    .cur  (st_r),
    .tick (tick),
    .nxt  (st_nxt),
    .done (done_nxt)
  );

  // Advance the sequencer only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= i2cram_pkg::ST_RESET;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on an accepted tick, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scl_r       <= st_nxt.scl;
      sda_r       <= st_nxt.sda;
      busy_r      <= st_nxt.active;
      done_r      <= done_nxt;
      read_data_r <= st_nxt.received_byte;
      nack_r      <= st_nxt.nack;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_level = scl_r;
  assign out_ch.sda_level = sda_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.read_data = read_data_r;
  assign out_ch.nack_seen = nack_r;

  // A transfer that begins is busy on the next cycle with its flag cleared.
  `I2CRAM_ASSERT_NEXT(a_begin_busy, begin_fire, st_r.active && !st_r.nack)
  // Done ends the transfer.
  `I2CRAM_ASSERT_NEXT(a_done_idle, in_fire && done_nxt, !st_r.active && out_ch.done_res)
  // Every accepted tick leaves a result.
  `I2CRAM_ASSERT_NEXT(a_tick_result, in_fire, out_valid_r)
  // The segment position stays inside the running program.
  `I2CRAM_ASSERT_NOW(a_seg_range, st_r.active,
    (st_r.is_read && st_r.seg_idx <= i2cram_pkg::RD_LAST) ||
    (!st_r.is_read && st_r.seg_idx <= i2cram_pkg::WR_LAST))

endmodule

// ===== hdl/i2cram_step.sv =====
// ----------------------------------------------------------------------------
// I2C register access master: one-tick sequencer step
// Computes the next sequencer state for one tick: at most one pin operation.
// ----------------------------------------------------------------------------
module i2cram_step (
  input  i2cram_pkg::seq_state_t cur,
  input  i2cram_pkg::tick_in_t   tick,
  output i2cram_pkg::seq_state_t nxt,
  output logic                   done
);

  i2cram_pkg::seq_state_t w;
  logic       start_xfer;
  logic [3:0] seg;
  logic [3:0] last_idx;
  logic       seg_end;
  logic [7:0] tx_byte;

  always_comb begin
    start_xfer = !cur.active &&
                 (tick.action == i2cram_pkg::ACT_WRITE || tick.action == i2cram_pkg::ACT_READ);
    w = cur;
    if (start_xfer) begin
      w.active    = 1'b1;
      w.is_read   = (tick.action == i2cram_pkg::ACT_READ);
      w.held_dev  = tick.dev_address;
      w.held_reg  = tick.reg_address;
      w.held_data = tick.write_data;
      w.nack      = 1'b0;
      w.seg_idx   = 4'd0;
      w.phase     = 2'd0;
      w.bit_cnt   = 3'd0;
    end

    seg      = i2cram_pkg::seg_code(w.is_read, w.seg_idx);
    last_idx = w.is_read ? i2cram_pkg::RD_LAST : i2cram_pkg::WR_LAST;
    case (seg)
      i2cram_pkg::SEG_TX_DEV:  tx_byte = w.held_dev;
      i2cram_pkg::SEG_TX_REG:  tx_byte = w.held_reg;
      i2cram_pkg::SEG_TX_DATA: tx_byte = w.held_data;
      default:                 tx_byte = w.held_dev | i2cram_pkg::READ_BIT;
    endcase

    nxt     = w;
    done    = 1'b0;
    seg_end = 1'b0;

    if (w.active) begin
      case (seg)
        i2cram_pkg::SEG_START, i2cram_pkg::SEG_ACK: begin
          case (w.phase)
            2'd0:    nxt.sda = 1'b1;
            2'd1:    nxt.scl = 1'b1;
            2'd2: begin
              if (seg == i2cram_pkg::SEG_START) nxt.sda = 1'b0;
              else nxt.nack = w.nack | tick.sda_in;
            end
            default: nxt.scl = 1'b0;
          endcase
          seg_end = (w.phase == 2'd3);
        end
        i2cram_pkg::SEG_STOP: begin
          case (w.phase)
            2'd0:    nxt.sda = 1'b0;
            2'd1:    nxt.scl = 1'b1;
            default: nxt.sda = 1'b1;
          endcase
          seg_end = (w.phase == 2'd2);
        end
        i2cram_pkg::SEG_NACK: begin
          case (w.phase)
            2'd0:    nxt.sda = 1'b1;
            2'd1:    nxt.scl = 1'b1;
            default: nxt.scl = 1'b0;
          endcase
          seg_end = (w.phase == 2'd2);
        end
        i2cram_pkg::SEG_RX: begin
          case (w.phase)
            i2cram_pkg::PH_RX_PRE: begin
              nxt.sda        = 1'b1;
              nxt.shift_byte = 8'd0;
              nxt.bit_cnt    = 3'd0;
            end
            2'd0: nxt.scl = 1'b1;
            2'd1: nxt.shift_byte[~w.bit_cnt] = w.shift_byte[~w.bit_cnt] | tick.sda_in;
            default: begin
              nxt.scl = 1'b0;
              if (w.bit_cnt == 3'd7) begin
                nxt.received_byte = w.shift_byte;
                seg_end           = 1'b1;
              end
            end
          endcase
        end
        default: begin
          case (w.phase)
            2'd0: begin
              nxt.shift_byte = tx_byte;
              nxt.sda        = tx_byte[~w.bit_cnt];
            end
            2'd1:    nxt.scl = 1'b1;
            default: nxt.scl = 1'b0;
          endcase
          seg_end = (w.phase == 2'd2) && (w.bit_cnt == 3'd7);
        end
      endcase

      // Advance the phase, bit and segment position.
      if (seg_end) begin
        nxt.bit_cnt = 3'd0;
        if (w.seg_idx == last_idx) begin
          nxt.active  = 1'b0;
          nxt.seg_idx = 4'd0;
          nxt.phase   = 2'd0;
          done        = 1'b1;
        end else begin
          nxt.seg_idx = w.seg_idx + 4'd1;
          nxt.phase   = (i2cram_pkg::seg_code(w.is_read, w.seg_idx + 4'd1) ==
                         i2cram_pkg::SEG_RX) ? i2cram_pkg::PH_RX_PRE : 2'd0;
        end
      end else if (seg == i2cram_pkg::SEG_RX || seg == i2cram_pkg::SEG_TX_DEV ||
                   seg == i2cram_pkg::SEG_TX_REG || seg == i2cram_pkg::SEG_TX_DATA ||
                   seg == i2cram_pkg::SEG_TX_DEVR) begin
        if (w.phase == i2cram_pkg::PH_RX_PRE) begin
          nxt.phase = 2'd0;
        end else if (w.phase == 2'd2) begin
          nxt.phase   = 2'd0;
          nxt.bit_cnt = w.bit_cnt + 3'd1;
        end else begin
          nxt.phase = w.phase + 2'd1;
        end
      end else begin
        nxt.phase = w.phase + 2'd1;
      end
    end
  end

endmodule

// ===== verif/tb_i2c_register_access_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master: testbench
// Drives pacing ticks into the bit-level master and compares every pin result
// against a cycle-free model of the write and read programs. A directed
// table covers idle ticks, extreme bytes, ignored begins and sticky NACKs.
// A randomized run of whole transfers with noise follows. Handshakes idle and
// stall in phases, with one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_i2c_register_access_master;

  // Action value with no meaning of its own; the block treats it as a tick.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // Ways to fill sda_in across the ticks of one stimulus row or transfer.
  localparam logic [1:0] FILL_LOW  = 2'd0;
  localparam logic [1:0] FILL_HIGH = 2'd1;
  localparam logic [1:0] FILL_ALT  = 2'd2;
  localparam logic [1:0] FILL_RAND = 2'd3;

  localparam int WRITE_TICKS  = 91;
  localparam int READ_TICKS   = 123;
  localparam int RANDOM_TICKS = 560;
  localparam int PHASE_LEN    = 160;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [2:0] {
    PACE_FREE,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH,
    PACE_FREE_TAIL
  } pace_t;

  // One pin result, in the order of the output channel.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       nack;
  } pin_res_t;

  // One row of the directed stimulus: a first tick with the row's action and
  // bytes, followed by plain ticks up to span.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] dev;
    logic [7:0] rgs;
    logic [7:0] data;
    logic [1:0] fill;
    logic [7:0] span;
    logic       typed;
    pin_res_t   first_res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  i2cram_in_if  in_ch ();
  i2cram_out_if out_ch ();

  i2c_register_access_master dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Model state of the sequencer
  // --------------------------------------------------------------------------
  logic [6:0] seq_pos;       // 0 idle, else 1 + index of the next pin operation
  logic       seq_is_read;
  logic [7:0] shifter;
  logic [2:0] bit_idx;
  logic [7:0] dev_byte;
  logic [7:0] reg_byte;
  logic [7:0] data_byte;
  logic [7:0] rx_byte;
  logic       scl_drv;
  logic       sda_drv;
  logic       nack_sticky;

  logic [3:0] write_plan [0:7] = '{
    i2cram_pkg::SEG_START, i2cram_pkg::SEG_TX_DEV, i2cram_pkg::SEG_ACK,
    i2cram_pkg::SEG_TX_REG, i2cram_pkg::SEG_ACK, i2cram_pkg::SEG_TX_DATA,
    i2cram_pkg::SEG_ACK, i2cram_pkg::SEG_STOP
  };
  logic [3:0] read_plan [0:10] = '{
    i2cram_pkg::SEG_START, i2cram_pkg::SEG_TX_DEV, i2cram_pkg::SEG_ACK,
    i2cram_pkg::SEG_TX_REG, i2cram_pkg::SEG_ACK,
    i2cram_pkg::SEG_START, i2cram_pkg::SEG_TX_DEVR, i2cram_pkg::SEG_ACK,
    i2cram_pkg::SEG_RX, i2cram_pkg::SEG_NACK, i2cram_pkg::SEG_STOP
  };

  // Stimulus and scoreboard storage
  i2cram_pkg::tick_in_t tick_plan [$];
  pin_res_t             typed_expect [int];
  pin_res_t             pending_pins [$];
  dir_row_t             directed_rows [0:12];

  int    ticks_taken     = 0;
  int    results_checked = 0;
  int    error_count     = 0;
  int    writes_begun    = 0;
  int    reads_begun     = 0;
  int    stops_seen      = 0;
  int    acks_high       = 0;
  int    directed_ticks  = 0;
  bit    stimulus_done   = 1'b0;
  pace_t pace_phase      = PACE_FREE;
  logic  hold_request    = 1'b0;

  // --------------------------------------------------------------------------
  // Predict the pin result of one accepted tick and advance the model.
  // --------------------------------------------------------------------------
  function automatic pin_res_t predict_pin_step(input i2cram_pkg::tick_in_t t);
    pin_res_t    r;
    int unsigned pos, len, k, s, nseg, i;
    logic [3:0]  seg;
    logic [7:0]  tx;
    logic        found, fin;
    found = 1'b0;
    fin   = 1'b0;
    // Latch a begin only in idle; begins while busy fall through as ticks.
    if (seq_pos == 7'd0 && (t.action == i2cram_pkg::ACT_WRITE ||
                            t.action == i2cram_pkg::ACT_READ)) begin
      seq_is_read = (t.action == i2cram_pkg::ACT_READ);
      dev_byte    = t.dev_address;
      reg_byte    = t.reg_address;
      data_byte   = t.write_data;
      nack_sticky = 1'b0;
      seq_pos     = 7'd1;
      if (seq_is_read) reads_begun++;
      else writes_begun++;
    end
    if (seq_pos != 7'd0) begin
      nseg = seq_is_read ? 11 : 8;
      pos  = seq_pos - 1;
      for (i = 0; i < nseg && !found; i++) begin
        seg = seq_is_read ? read_plan[i] : write_plan[i];
        case (seg)
          i2cram_pkg::SEG_START, i2cram_pkg::SEG_ACK: len = 4;
          i2cram_pkg::SEG_RX:                         len = 25;
          i2cram_pkg::SEG_NACK, i2cram_pkg::SEG_STOP: len = 3;
          default:                                    len = 24;
        endcase
        if (pos < len) begin
          found = 1'b1;
          case (seg)
            i2cram_pkg::SEG_START: begin
              case (pos)
                0:       sda_drv = 1'b1;
                1:       scl_drv = 1'b1;
                2:       sda_drv = 1'b0;
                default: scl_drv = 1'b0;
              endcase
            end
            i2cram_pkg::SEG_STOP: begin
              case (pos)
                0:       sda_drv = 1'b0;
                1:       scl_drv = 1'b1;
                default: sda_drv = 1'b1;
              endcase
            end
            i2cram_pkg::SEG_ACK: begin
              case (pos)
                0: sda_drv = 1'b1;
                1: scl_drv = 1'b1;
                2: begin
                  nack_sticky = nack_sticky | t.sda_in;
                  if (t.sda_in) acks_high++;
                end
                default: scl_drv = 1'b0;
              endcase
            end
            i2cram_pkg::SEG_NACK: begin
              case (pos)
                0:       sda_drv = 1'b1;
                1:       scl_drv = 1'b1;
                default: scl_drv = 1'b0;
              endcase
            end
            i2cram_pkg::SEG_RX: begin
              if (pos == 0) begin
                sda_drv = 1'b1;
                shifter = 8'h00;
                bit_idx = 3'd0;
              end else begin
                k = ((pos - 1) / 3) & 7;
                s = (pos - 1) % 3;
                bit_idx = k[2:0];
                if (s == 0) scl_drv = 1'b1;
                else if (s == 1) begin
                  if (t.sda_in) shifter = shifter | (8'h80 >> k);
                end else begin
                  scl_drv = 1'b0;
                  if (k == 7) rx_byte = shifter;
                end
              end
            end
            default: begin
              case (seg)
                i2cram_pkg::SEG_TX_DEV:  tx = dev_byte;
                i2cram_pkg::SEG_TX_REG:  tx = reg_byte;
                i2cram_pkg::SEG_TX_DATA: tx = data_byte;
                default:                 tx = dev_byte | i2cram_pkg::READ_BIT;
              endcase
              k = (pos / 3) & 7;
              s = pos % 3;
              bit_idx = k[2:0];
              if (s == 0) begin
                shifter = tx;
                sda_drv = shifter[7 - k];
              end else if (s == 1) scl_drv = 1'b1;
              else scl_drv = 1'b0;
            end
          endcase
          if (i == nseg - 1 && pos == len - 1) begin
            fin     = 1'b1;
            seq_pos = 7'd0;
            stops_seen++;
          end else begin
            seq_pos = seq_pos + 7'd1;
          end
        end else begin
          pos = pos - len;
        end
      end
      // A position past the program drops back to idle.
      if (!found) seq_pos = 7'd0;
    end
    r.scl   = scl_drv;
    r.sda   = sda_drv;
    r.busy  = (seq_pos != 7'd0);
    r.done  = fin;
    r.rdata = rx_byte;
    r.nack  = nack_sticky;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock: 8 ns period.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if the scoreboard never drains.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender: walk the tick plan, one transaction per offered item. Only pick a
  // new item or a gap once the current one has been taken, so valid never
  // drops under a pending transaction.
  // --------------------------------------------------------------------------
  initial begin : sender
    int idx;
    bit rest;
    idx = 0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= i2cram_pkg::ACT_TICK;
    in_ch.dev_address <= 8'h00;
    in_ch.reg_address <= 8'h00;
    in_ch.write_data  <= 8'h00;
    in_ch.sda_in      <= 1'b1;
    wait (rst_n === 1'b1);
    while (idx < tick_plan.size()) begin
      @(posedge clk);
      if (!in_ch.valid || in_ch.ready) begin
        case (pace_phase)
          PACE_SEND_GAPS: rest = ($urandom_range(0, 99) < 72);
          PACE_BOTH:      rest = ($urandom_range(0, 99) < 38);
          default:        rest = 1'b0;
        endcase
        if (rest) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid       <= 1'b1;
          in_ch.action      <= tick_plan[idx].action;
          in_ch.dev_address <= tick_plan[idx].dev_address;
          in_ch.reg_address <= tick_plan[idx].reg_address;
          in_ch.write_data  <= tick_plan[idx].write_data;
          in_ch.sda_in      <= tick_plan[idx].sda_in;
          idx++;
          // Advance the pacing phase with the stimulus, and ask once for the
          // long output hold-off while the sender runs without gaps.
          pace_phase <= pace_t'((idx / PHASE_LEN) % 5);
          if (idx == HOLD_AT) hold_request <= 1'b1;
        end
      end
    end
    // Hold the last item until it is taken, then drop valid.
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid   <= 1'b0;
    stimulus_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall by phase, and once hold ready low for a long stretch so
  // the result register fills and the input side backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    bit hold_served;
    bit stall;
    hold_left   = 0;
    hold_served = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (pace_phase)
          PACE_RECV_STALLS: stall = ($urandom_range(0, 99) < 72);
          PACE_BOTH:        stall = ($urandom_range(0, 99) < 38);
          default:          stall = 1'b0;
        endcase
        out_ch.ready <= !stall;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every accepted tick, then check every accepted
  // result against the oldest prediction. Push before pop so a result that
  // belongs to an earlier tick still lines up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    i2cram_pkg::tick_in_t t;
    pin_res_t             want, got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        t.action      = in_ch.action;
        t.dev_address = in_ch.dev_address;
        t.reg_address = in_ch.reg_address;
        t.write_data  = in_ch.write_data;
        t.sda_in      = in_ch.sda_in;
        want = predict_pin_step(t);
        // Rows with a hand-typed result take that in place of the model.
        if (typed_expect.exists(ticks_taken)) want = typed_expect[ticks_taken];
        pending_pins.push_back(want);
        ticks_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.scl   = out_ch.scl_level;
        got.sda   = out_ch.sda_level;
        got.busy  = out_ch.busy_res;
        got.done  = out_ch.done_res;
        got.rdata = out_ch.read_data;
        got.nack  = out_ch.nack_seen;
        if (pending_pins.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR result %0d arrived with no tick pending", results_checked);
        end else begin
          want = pending_pins.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
              got.done !== want.done || got.rdata !== want.rdata ||
              got.nack !== want.nack) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"ERROR result %0d: expected scl=%b sda=%b busy=%b done=%b",
                        " data=%h nack=%b, got scl=%b sda=%b busy=%b done=%b",
                        " data=%h nack=%b"},
                       results_checked, want.scl, want.sda, want.busy, want.done,
                       want.rdata, want.nack, got.scl, got.sda, got.busy, got.done,
                       got.rdata, got.nack);
          end
        end
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main flow: build the stimulus, reset, wait for the drain, report.
  // --------------------------------------------------------------------------
  initial begin : main_flow
    i2cram_pkg::tick_in_t t;
    int                   r, j, len, gap;
    bit                   is_rd;
    logic [1:0]           policy;
    rst_n <= 1'b0;

    // Reset state of the model: idle, lines released, bytes and flags clear.
    seq_pos     = 7'd0;
    seq_is_read = 1'b0;
    shifter     = 8'h00;
    bit_idx     = 3'd0;
    dev_byte    = 8'h00;
    reg_byte    = 8'h00;
    data_byte   = 8'h00;
    rx_byte     = 8'h00;
    scl_drv     = 1'b1;
    sda_drv     = 1'b1;
    nack_sticky = 1'b0;

    // Directed rows. The typed result applies to the row's first tick.
    //   action     dev    reg    data   fill       span typed  scl  sda  busy done data nack
    directed_rows = '{
      // idle tick straight after reset
      '{i2cram_pkg::ACT_TICK,  8'h00, 8'h00, 8'h00, FILL_LOW,  8'd1,   1'b1,
         '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      // spare action in idle does nothing
      '{ACT_SPARE,             8'hFF, 8'hFF, 8'hFF, FILL_HIGH, 8'd1,   1'b1,
         '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      // all-zero write, every ack slot pulled low
      '{i2cram_pkg::ACT_WRITE, 8'h00, 8'h00, 8'h00, FILL_LOW,  8'd91,  1'b1,
         '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{i2cram_pkg::ACT_TICK,  8'h00, 8'h00, 8'h00, FILL_LOW,  8'd1,   1'b1,
         '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      // all-ones write with SDA floating; a read begin lands mid-transfer
      '{i2cram_pkg::ACT_WRITE, 8'hFF, 8'hFF, 8'hFF, FILL_HIGH, 8'd40,  1'b1,
         '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{i2cram_pkg::ACT_READ,  8'h5A, 8'hC3, 8'h3C, FILL_HIGH, 8'd51,  1'b0,
         '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
      // sticky NACK survives into idle
      '{i2cram_pkg::ACT_TICK,  8'h00, 8'h00, 8'h00, FILL_HIGH, 8'd1,   1'b1,
         '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
      // read with SDA floating: begin clears the NACK, byte reads all ones
      '{i2cram_pkg::ACT_READ,  8'h00, 8'h00, 8'h00, FILL_HIGH, 8'd123, 1'b1,
         '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{i2cram_pkg::ACT_TICK,  8'h00, 8'h00, 8'h00, FILL_LOW,  8'd1,   1'b1,
         '{1'b1, 1'b1, 1'b0, 1'b0, 8'hFF, 1'b1}},
      // read with alternating SDA, device byte already odd
      '{i2cram_pkg::ACT_READ,  8'hFF, 8'hA5, 8'h00, FILL_ALT,  8'd123, 1'b0,
         '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
      // write keeps the last read byte
      '{i2cram_pkg::ACT_WRITE, 8'h81, 8'h7E, 8'h5A, FILL_ALT,  8'd91,  1'b0,
         '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
      // read with SDA held low: clean acks, zero byte
      '{i2cram_pkg::ACT_READ,  8'h80, 8'h01, 8'hFF, FILL_LOW,  8'd123, 1'b0,
         '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{ACT_SPARE,             8'h00, 8'h00, 8'h00, FILL_LOW,  8'd1,   1'b1,
         '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}}
    };

    for (r = 0; r < 13; r++) begin
      for (j = 0; j < directed_rows[r].span; j++) begin
        t.action      = (j == 0) ? directed_rows[r].action : i2cram_pkg::ACT_TICK;
        t.dev_address = (j == 0) ? directed_rows[r].dev : 8'h00;
        t.reg_address = (j == 0) ? directed_rows[r].rgs : 8'h00;
        t.write_data  = (j == 0) ? directed_rows[r].data : 8'h00;
        case (directed_rows[r].fill)
          FILL_LOW:  t.sda_in = 1'b0;
          FILL_HIGH: t.sda_in = 1'b1;
          FILL_ALT:  t.sda_in = j[0];
          default:   t.sda_in = 1'($urandom_range(0, 1));
        endcase
        if (j == 0 && directed_rows[r].typed)
          typed_expect[tick_plan.size()] = directed_rows[r].first_res;
        tick_plan.push_back(t);
      end
    end
    directed_ticks = tick_plan.size();

    // Random part: mostly complete transfers with random bytes, stray actions
    // sprinkled in (ignored while busy), and short noisy gaps between them
    // that may start a transfer of their own and swallow the next begin.
    while (tick_plan.size() < directed_ticks + RANDOM_TICKS) begin
      if ($urandom_range(0, 99) < 82) begin
        is_rd = 1'($urandom_range(0, 1));
        len   = is_rd ? READ_TICKS : WRITE_TICKS;
        case ($urandom_range(0, 2))
          0:       policy = FILL_LOW;
          1:       policy = FILL_HIGH;
          default: policy = FILL_RAND;
        endcase
        for (j = 0; j < len; j++) begin
          t.dev_address = 8'($urandom_range(0, 255));
          t.reg_address = 8'($urandom_range(0, 255));
          t.write_data  = 8'($urandom_range(0, 255));
          if (j == 0) t.action = is_rd ? i2cram_pkg::ACT_READ : i2cram_pkg::ACT_WRITE;
          else if ($urandom_range(0, 9) == 0) t.action = 2'($urandom_range(0, 3));
          else t.action = i2cram_pkg::ACT_TICK;
          case (policy)
            FILL_LOW:  t.sda_in = ($urandom_range(0, 19) == 0);
            FILL_HIGH: t.sda_in = ($urandom_range(0, 19) != 0);
            default:   t.sda_in = 1'($urandom_range(0, 1));
          endcase
          tick_plan.push_back(t);
        end
      end else begin
        gap = $urandom_range(1, 4);
        for (j = 0; j < gap; j++) begin
          t.dev_address = 8'($urandom_range(0, 255));
          t.reg_address = 8'($urandom_range(0, 255));
          t.write_data  = 8'($urandom_range(0, 255));
          t.sda_in      = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 3) == 0) t.action = 2'($urandom_range(0, 3));
          else t.action = $urandom_range(0, 1) ? ACT_SPARE : i2cram_pkg::ACT_TICK;
          tick_plan.push_back(t);
        end
      end
    end

    // Hold reset, then release it for good.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait for every prediction to be matched, then idle a little
    // longer to catch any stray result.
    wait (stimulus_done);
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d ticks (%0d directed), checked %0d pin results, %0d mismatches",
             ticks_taken, directed_ticks, results_checked, error_count);
    $display("Transfers: %0d writes and %0d reads begun, %0d stops, %0d ack slots high",
             writes_begun, reads_begun, stops_seen, acks_high);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
